[sv/crtc_pkg.sv]
// Types and constants shared by the CRT timing controller.
// Depends on nothing; used by crt_controller_timing_tick.
package crtc_pkg;

    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    localparam int unsigned NUM_TREGS = 16;

    // timing register numbers
    localparam logic [3:0] R_HTOTAL     = 4'd0;
    localparam logic [3:0] R_HDISP      = 4'd1;
    localparam logic [3:0] R_HSYNC_POS  = 4'd2;
    localparam logic [3:0] R_VTOTAL     = 4'd4;
    localparam logic [3:0] R_VADJUST    = 4'd5;
    localparam logic [3:0] R_VDISP      = 4'd6;
    localparam logic [3:0] R_VSYNC_POS  = 4'd7;
    localparam logic [3:0] R_INTERLACE  = 4'd8;
    localparam logic [3:0] R_MAX_RASTER = 4'd9;
    localparam logic [3:0] R_START_HI   = 4'd12;
    localparam logic [3:0] R_START_LO   = 4'd13;

    localparam logic [1:0] INTERLACE_SYNC_VIDEO = 2'b11;

    // configuration register indexes
    localparam logic [3:0] CFG_HSYNC_WIDTH = 4'd0;
    localparam logic [3:0] CFG_VSYNC_WIDTH = 4'd1;

    localparam logic [3:0] HSYNC_WIDTH_RESET = 4'd14;
    localparam logic [4:0] VSYNC_WIDTH_RESET = 5'd16;

    typedef struct packed {
        logic       action;
        logic [3:0] reg_select;
        logic [7:0] reg_value;
    } in_item_t;

    typedef struct packed {
        logic        h_display;
        logic        hsync;
        logic        v_display;
        logic        vsync;
        logic        hsync_rise;
        logic        hsync_fall;
        logic [13:0] mem_address;
        logic [4:0]  raster_address;
        logic [7:0]  char_count;
        logic [6:0]  row_count;
        logic        odd_field;
    } out_item_t;

    typedef struct packed {
        logic hdisp;
        logic hsync;
        logic vdisp;
        logic vsync;
        logic adjust_phase;
        logic addr_from_start;
        logic odd_field;
        logic v_guard;
        logic h_guard;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{
        hdisp: 1'b0, hsync: 1'b0, vdisp: 1'b0, vsync: 1'b0,
        adjust_phase: 1'b0, addr_from_start: 1'b0, odd_field: 1'b0,
        v_guard: 1'b1, h_guard: 1'b1
    };

endpackage

[sv/crt_controller_timing_tick.sv]
// CRT timing controller (6845 type 2 style): one character clock per tick item.
// Depends on crtc_pkg.
//
// Use:
//   in_*   : items of type crtc_pkg::in_item_t. action = tick advances all counters by one
//            character clock; action = write stores reg_value in timing register reg_select.
//   out_*  : one crtc_pkg::out_item_t per input item, in order, showing the state after it.
//   cfg_*  : register 0 = hsync width (4 bits), 1 = vsync width (5 bits); other indexes are
//            ignored. Always ready; write only while the block is idle.
// Throughput: one item per cycle unless the output stalls; each result is registered on out_*.
// The character tick update is one pass of logic between
//   the input register and the state/result registers, so item n+1 sees the state item n left.
// Reset: timing registers and all counters clear, display and sync flip-flops off, sync
//   widths 14 and 16.
// Stall: the result register holds while out_ready is low; one further item waits in the
//   input register, after which in_ready drops.
module crt_controller_timing_tick
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  crtc_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output crtc_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    logic                s1_valid_reg;
    crtc_pkg::in_item_t  s1_item_reg;
    logic                out_valid_reg;
    crtc_pkg::out_item_t out_data_reg;
    logic                advance;

    logic [7:0]  tregs_reg [crtc_pkg::NUM_TREGS];
    logic [3:0]  hsync_width_reg;
    logic [4:0]  vsync_width_reg;

    logic [7:0]  char_reg, char_next;
    logic [4:0]  raster_reg, raster_next;
    logic [6:0]  row_reg, row_next;
    logic [4:0]  adjust_reg, adjust_next;
    logic [4:0]  vsc_reg, vsc_next;
    logic [4:0]  hsc_reg, hsc_next;
    logic [13:0] addr_reg, addr_next;
    logic [13:0] rsl_reg, rsl_next;
    crtc_pkg::ctl_t ctl_reg, ctl_next;
    crtc_pkg::out_item_t result;

    logic hd_set, hd_rst, hs_set, hs_rst, vd_set, vd_rst, vs_set, vs_rst;
    logic rise, fall, end_adjust, last_raster, il3;
    logic [7:0] r0, r1, r2, r4, r5, r6, r7, r9;
    logic [13:0] start_addr;

    assign r0 = tregs_reg[crtc_pkg::R_HTOTAL];
    assign r1 = tregs_reg[crtc_pkg::R_HDISP];
    assign r2 = tregs_reg[crtc_pkg::R_HSYNC_POS];
    assign r4 = tregs_reg[crtc_pkg::R_VTOTAL];
    assign r5 = tregs_reg[crtc_pkg::R_VADJUST];
    assign r6 = tregs_reg[crtc_pkg::R_VDISP];
    assign r7 = tregs_reg[crtc_pkg::R_VSYNC_POS];
    assign r9 = tregs_reg[crtc_pkg::R_MAX_RASTER];
    assign il3 = tregs_reg[crtc_pkg::R_INTERLACE][1:0] == crtc_pkg::INTERLACE_SYNC_VIDEO;
    assign start_addr = {tregs_reg[crtc_pkg::R_START_HI][5:0], tregs_reg[crtc_pkg::R_START_LO]};

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // one character clock step, in the order the counters depend on each other
    always_comb
    begin
        char_next   = char_reg;
        raster_next = raster_reg;
        row_next    = row_reg;
        adjust_next = adjust_reg;
        vsc_next    = vsc_reg;
        hsc_next    = hsc_reg;
        addr_next   = addr_reg;
        rsl_next    = rsl_reg;
        ctl_next    = ctl_reg;
        hd_set = 1'b0; hd_rst = 1'b0; hs_set = 1'b0; hs_rst = 1'b0;
        vd_set = 1'b0; vd_rst = 1'b0; vs_set = 1'b0; vs_rst = 1'b0;
        rise = 1'b0; fall = 1'b0; end_adjust = 1'b0; last_raster = 1'b0;

        if (s1_item_reg.action == crtc_pkg::ACTION_TICK)
        begin
            if (char_next == r0)
            begin
                char_next = 8'd0;
            end
            else
            begin
                char_next = char_next + 8'd1;
                addr_next = addr_next + 14'd1;
            end

            if (ctl_reg.hsync)
            begin
                hsc_next = hsc_next + 5'd1;
            end

            if (char_next == 8'd0)
            begin
                if (ctl_reg.vsync)
                begin
                    vsc_next = vsc_next + 5'd1;
                    if (vsc_next == vsync_width_reg)
                    begin
                        vsc_next = 5'd0;
                        vs_rst   = 1'b1;
                    end
                end
                if (ctl_next.adjust_phase)
                begin
                    adjust_next = adjust_next + 5'd1;
                end

                last_raster = {3'b000, raster_next} == r9;
                if (last_raster
                    || (il3 && {2'b00, {1'b0, raster_next} + 6'd1} == r9))
                begin
                    raster_next = 5'd0;
                    if ({1'b0, row_next} == r4)
                    begin
                        ctl_next.adjust_phase = 1'b1;
                    end
                    row_next = row_next + 7'd1;
                end
                else
                begin
                    raster_next = raster_next + (il3 ? 5'd2 : 5'd1);
                end

                end_adjust = ctl_next.adjust_phase && ({3'b000, adjust_next} == r5);
                if ({3'b000, adjust_next} == r5)
                begin
                    adjust_next = 5'd0;
                end

                if (end_adjust)
                begin
                    ctl_next.addr_from_start = 1'b1;
                end
                else if (last_raster)
                begin
                    ctl_next.addr_from_start = 1'b0;
                end

                addr_next = ctl_next.addr_from_start ? start_addr : rsl_next;
            end

            if (char_next == r1 && {3'b000, raster_next} == r9)
            begin
                rsl_next = addr_next;
            end

            if (char_next == 8'd0)
            begin
                if (end_adjust)
                begin
                    raster_next = 5'd0;
                end
                if (ctl_next.addr_from_start)
                begin
                    ctl_next.adjust_phase = 1'b0;
                    vd_set                = 1'b1;
                    row_next              = 7'd0;
                    ctl_next.odd_field    = !ctl_next.odd_field;
                end
            end

            if ({1'b0, row_next} == r7)
            begin
                if (ctl_next.v_guard)
                begin
                    vs_set           = 1'b1;
                    ctl_next.v_guard = 1'b0;
                end
            end
            else
            begin
                ctl_next.v_guard = 1'b1;
            end

            if ({1'b0, row_next} == r6)
            begin
                vd_rst = 1'b1;
            end
            if (char_next == 8'd0)
            begin
                hd_set = 1'b1;
            end

            if (char_next == r2)
            begin
                if (ctl_next.h_guard)
                begin
                    ctl_next.h_guard = 1'b0;
                    rise             = 1'b1;
                    hs_set           = 1'b1;
                end
            end
            else
            begin
                ctl_next.h_guard = 1'b1;
            end

            if (hsc_next >= {1'b0, hsync_width_reg} && (ctl_reg.hsync || rise))
            begin
                fall     = 1'b1;
                hs_rst   = 1'b1;
                hsc_next = 5'd0;
            end

            if (char_next == r1)
            begin
                hd_rst = 1'b1;
            end

            // display enable: reset wins; the others hold when set and reset meet
            ctl_next.hdisp = hd_rst ? 1'b0 : (hd_set ? 1'b1 : ctl_reg.hdisp);
            if (hs_set != hs_rst)
            begin
                ctl_next.hsync = hs_set;
            end
            if (vd_set != vd_rst)
            begin
                ctl_next.vdisp = vd_set;
            end
            if (vs_set != vs_rst)
            begin
                ctl_next.vsync = vs_set;
            end
        end

        result.h_display      = ctl_next.hdisp;
        result.hsync          = ctl_next.hsync;
        result.v_display      = ctl_next.vdisp;
        result.vsync          = ctl_next.vsync;
        result.hsync_rise     = rise;
        result.hsync_fall     = fall;
        result.mem_address    = addr_next;
        result.raster_address = raster_next;
        result.char_count     = char_next;
        result.row_count      = row_next;
        result.odd_field      = ctl_next.odd_field;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsync_width_reg <= crtc_pkg::HSYNC_WIDTH_RESET;
            vsync_width_reg <= crtc_pkg::VSYNC_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == crtc_pkg::CFG_HSYNC_WIDTH)
            begin
                hsync_width_reg <= cfg_data[3:0];
            end
            else if (cfg_index == crtc_pkg::CFG_VSYNC_WIDTH)
            begin
                vsync_width_reg <= cfg_data[4:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < crtc_pkg::NUM_TREGS; i++)
            begin
                tregs_reg[i] <= 8'd0;
            end
            char_reg   <= 8'd0;
            raster_reg <= 5'd0;
            row_reg    <= 7'd0;
            adjust_reg <= 5'd0;
            vsc_reg    <= 5'd0;
            hsc_reg    <= 5'd0;
            addr_reg   <= 14'd0;
            rsl_reg    <= 14'd0;
            ctl_reg    <= crtc_pkg::CTL_RESET;
        end
        else if (advance)
        begin
            if (s1_item_reg.action == crtc_pkg::ACTION_WRITE)
            begin
                tregs_reg[s1_item_reg.reg_select] <= s1_item_reg.reg_value;
            end
            char_reg   <= char_next;
            raster_reg <= raster_next;
            row_reg    <= row_next;
            adjust_reg <= adjust_next;
            vsc_reg    <= vsc_next;
            hsc_reg    <= hsc_next;
            addr_reg   <= addr_next;
            rsl_reg    <= rsl_next;
            ctl_reg    <= ctl_next;
        end
    end

    a_write_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_item_reg.action == crtc_pkg::ACTION_WRITE
        |=> !out_data.hsync_rise && !out_data.hsync_fall)
        else $error("hsync pulse on a register write item");

    a_rise_sets_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hsync_rise |-> out_data.hsync || out_data.hsync_fall)
        else $error("hsync rise without sync flip-flop set");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid && !out_ready)
        else $error("input stalled without a downstream stall");

    a_write_keeps_counters: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_item_reg.action == crtc_pkg::ACTION_WRITE
        |=> $stable(char_reg) && $stable(addr_reg) && $stable(raster_reg))
        else $error("counters moved on a register write item");

endmodule
